[sv/gtu_pkg.sv]
// Shared constants for the trilinear grid upsampler.
package gtu_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W    = 13;
  localparam int unsigned LOAD_IDX_W = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SCALE_W    = 9;
  localparam int unsigned SIDE_W     = 6;

  // Default parameter values
  localparam int unsigned DEF_MAX_SIDE  = 32;
  localparam int unsigned DEF_FRAC_BITS = 12;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 9'd1;
  localparam logic [SIDE_W-1:0]  SIDE_RST  = 6'd32;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_IDX_BIT = 2;
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_SIDE  = 1'b1;

  // Item kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

[sv/grid_trilinear_upsample.sv]
// Trilinear upsampler: pipelined coordinate divide, replicated grid store, x/y/z blend stages.
// The coordinate divider has NS = ceil((13 + FRAC_BITS) / 4) stages, since the restoring
// divider retires 4 quotient bits per stage.
// Throughput: one item per cycle when not stalled; the 8 corner reads come from 4 copies of
// the grid store, each read at two addresses per cycle, so no port is shared between corners.
// Input stalls only while two results wait at the output; loads give no result.
// Reset clears valid bits and config registers; the grid store is undefined until loaded.
module grid_trilinear_upsample
  import gtu_pkg::*;
#(
  parameter int unsigned MAX_SIDE  = DEF_MAX_SIDE,
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [LOAD_IDX_W-1:0]      load_index_i,
  input  logic signed [SAMPLE_W-1:0] load_value_i,
  input  logic [COORD_W-1:0]         coord_x_i,
  input  logic [COORD_W-1:0]         coord_y_i,
  input  logic [COORD_W-1:0]         coord_z_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       out_of_range_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW    = $clog2(MAX_SIDE);
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned QW    = COORD_W + F;
  localparam int unsigned STEPS = 4;
  localparam int unsigned NS    = (QW + STEPS - 1) / STEPS;
  localparam int unsigned PW    = SAMPLE_W + 2 + F;
  // stage positions after the divider
  localparam int unsigned SP  = NS;
  localparam int unsigned SB  = NS + 1;
  localparam int unsigned SC  = NS + 2;
  localparam int unsigned SM  = NS + 3;
  localparam int unsigned SX1 = NS + 4;
  localparam int unsigned SX2 = NS + 5;
  localparam int unsigned SY1 = NS + 6;
  localparam int unsigned SY2 = NS + 7;
  localparam int unsigned SZ1 = NS + 8;
  localparam int unsigned SZ2 = NS + 9;
  localparam int unsigned NST = NS + 10;

  typedef struct packed {
    logic                       query;
    logic                       ld_ok;
    logic [AW-1:0]              ld_addr;
    logic signed [SAMPLE_W-1:0] ld_val;
  } ctrl_t;

  typedef struct packed {
    logic [SCALE_W-1:0] rem;
    logic [QW-1:0]      acc;
  } dlane_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       oor;
  } res_t;

  // Blend helpers: product of difference and fraction, then truncating add
  function automatic logic signed [PW-1:0] blend_mul(input logic signed [SAMPLE_W-1:0] a,
                                                     input logic signed [SAMPLE_W-1:0] b,
                                                     input logic [F-1:0] f);
    logic signed [SAMPLE_W:0] dif;
    logic signed [PW-1:0]     prod;
    dif  = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
    prod = dif * $signed({1'b0, f});
    return prod;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] blend_add(input logic signed [SAMPLE_W-1:0] a,
                                                           input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] quo;
    logic signed [PW-1:0] sum;
    rnd = prod[PW-1] ? PW'((2 ** F) - 1) : '0;
    quo = (prod + rnd) >>> F;
    sum = quo + {{(PW - SAMPLE_W){a[SAMPLE_W-1]}}, a};
    return sum[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SCALE_W-1:0]  scale_q;
  logic [SIDE_W-1:0]   side_q;
  logic [SCALE_W-1:0]  scale_eff;
  logic [SW-1:0]       side_eff;
  logic [2*SW-1:0]     side_sq_q;
  logic                cfg_we;

  assign cfg_we = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      side_q  <= SIDE_RST;
    end else if (cfg_we) begin
      case (paddr[REG_IDX_BIT])
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        REG_SIDE:  side_q  <= pwdata[SIDE_W-1:0];
        default:   scale_q <= scale_q;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[REG_IDX_BIT])
      REG_SCALE: prdata = APB_DW'(scale_q);
      REG_SIDE:  prdata = APB_DW'(side_q);
      default:   prdata = '0;
    endcase
  end

  // Clamp scale and side to usable values
  always_comb begin
    scale_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;
    side_eff  = (32'(side_q) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(side_q);
  end

  always_ff @(posedge clk_i) begin
    side_sq_q <= side_eff * side_eff;
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: whole pipe advances unless the output skid is full
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_q;
  logic           en;
  logic           head_v_q, skid_v_q;
  ctrl_t          c_ctl_q;

  assign en         = ~skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      for (int k = 0; k < NST; k++) begin
        if (k == 0) begin
          v_q[k] <= in_valid_i;
        end else if (k == SM) begin
          // drop loads once written
          v_q[k] <= v_q[k-1] & c_ctl_q.query;
        end else begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: (coord << F) / scale, four restoring steps per stage
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] coord [3];
  ctrl_t              in_ctl;
  dlane_t             dl_in [NS][3];
  dlane_t             dl_d  [NS][3];
  dlane_t             dl_q  [NS][3];
  ctrl_t              dctl_q [NS];

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  always_comb begin
    in_ctl.query   = (action_i == ACT_QUERY);
    in_ctl.ld_ok   = (32'(load_index_i) < DEPTH);
    in_ctl.ld_addr = AW'(load_index_i);
    in_ctl.ld_val  = load_value_i;
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dl_in[0][l].rem = '0;
        assign dl_in[0][l].acc = {coord[l], {F{1'b0}}};
      end
      always_ff @(posedge clk_i) begin
        if (en) dctl_q[0] <= in_ctl;
      end
    end else begin : g_next
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dl_in[k][l] = dl_q[k-1][l];
      end
      always_ff @(posedge clk_i) begin
        if (en) dctl_q[k] <= dctl_q[k-1];
      end
    end

    // Retire up to four quotient bits per lane
    always_comb begin
      dlane_t           cur;
      logic [SCALE_W:0] trial;
      logic             ge;
      for (int l = 0; l < 3; l++) begin
        cur = dl_in[k][l];
        for (int i = 0; i < STEPS; i++) begin
          if (k * STEPS + i < QW) begin
            trial   = {cur.rem, cur.acc[QW-1]};
            ge      = (trial >= {1'b0, scale_eff});
            cur.acc = {cur.acc[QW-2:0], ge};
            cur.rem = ge ? SCALE_W'(trial - {1'b0, scale_eff}) : SCALE_W'(trial);
          end
        end
        dl_d[k][l] = cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 3; l++) dl_q[k][l] <= dl_d[k][l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P: range check and address products
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0]   cell_idx [3];
  logic [F-1:0]         frac [3];
  logic                 oor_d;
  logic [CW+2*SW-1:0]   pz_full;
  logic [CW+SW-1:0]     py_full;

  ctrl_t         p_ctl_q;
  logic          p_oor_q;
  logic [AW-1:0] p_pz_q, p_py_q;
  logic [CW-1:0] p_cx_q;
  logic [F-1:0]  p_fr_q [3];

  always_comb begin
    oor_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      cell_idx[l] = dl_q[NS-1][l].acc[QW-1:F];
      frac[l]     = dl_q[NS-1][l].acc[F-1:0];
      if ((32'(cell_idx[l]) + 32'd1) >= 32'(side_eff)) oor_d = 1'b1;
    end
    pz_full = CW'(cell_idx[2]) * side_sq_q;
    py_full = CW'(cell_idx[1]) * side_eff;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ctl_q <= dctl_q[NS-1];
      p_oor_q <= oor_d;
      p_pz_q  <= AW'(pz_full);
      p_py_q  <= AW'(py_full);
      p_cx_q  <= CW'(cell_idx[0]);
      for (int l = 0; l < 3; l++) p_fr_q[l] <= frac[l];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: base address of the cell's lowest corner
  // ---------------------------------------------------------------------------
  ctrl_t         b_ctl_q;
  logic          b_oor_q;
  logic [AW-1:0] b_base_q;
  logic [F-1:0]  b_fr_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ctl_q  <= p_ctl_q;
      b_oor_q  <= p_oor_q;
      b_base_q <= p_pz_q + p_py_q + AW'(p_cx_q);
      for (int l = 0; l < 3; l++) b_fr_q[l] <= p_fr_q[l];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: eight corner addresses, two per store copy
  // ---------------------------------------------------------------------------
  logic [AW-1:0] row_base [4];
  logic          c_oor_q;
  logic [AW-1:0] c_addr_q [4][2];
  logic [F-1:0]  c_fr_q [3];

  always_comb begin
    row_base[0] = b_base_q;
    row_base[1] = b_base_q + AW'(side_eff);
    row_base[2] = b_base_q + AW'(side_sq_q);
    row_base[3] = b_base_q + AW'(side_sq_q) + AW'(side_eff);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ctl_q <= b_ctl_q;
      c_oor_q <= b_oor_q;
      for (int r = 0; r < 4; r++) begin
        c_addr_q[r][0] <= row_base[r];
        c_addr_q[r][1] <= row_base[r] + AW'(1);
      end
      for (int l = 0; l < 3; l++) c_fr_q[l] <= b_fr_q[l];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: grid store, four copies written together, each read at two addresses
  // ---------------------------------------------------------------------------
  logic                       mem_we;
  logic signed [SAMPLE_W-1:0] rd [4][2];
  logic                       m_oor_q;
  logic [F-1:0]               m_fy_q, m_fz_q, m_fx_q;

  assign mem_we = en & v_q[SC] & ~c_ctl_q.query & c_ctl_q.ld_ok;

  for (genvar c = 0; c < 4; c++) begin : g_copy
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd0_q, rd1_q;

    always_ff @(posedge clk_i) begin
      if (mem_we) mem[c_ctl_q.ld_addr] <= c_ctl_q.ld_val;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rd0_q <= mem[c_addr_q[c][0]];
        rd1_q <= mem[c_addr_q[c][1]];
      end
    end

    assign rd[c][0] = $signed(rd0_q);
    assign rd[c][1] = $signed(rd1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_oor_q <= c_oor_q;
      m_fx_q  <= c_fr_q[0];
      m_fy_q  <= c_fr_q[1];
      m_fz_q  <= c_fr_q[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Blend along x, then y, then z: multiply stage, then truncating add stage
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]       x_prod_q [4];
  logic signed [SAMPLE_W-1:0] x_a_q [4];
  logic                       x1_oor_q;
  logic [F-1:0]               x1_fy_q, x1_fz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        x_prod_q[r] <= blend_mul(rd[r][0], rd[r][1], m_fx_q);
        x_a_q[r]    <= rd[r][0];
      end
      x1_oor_q <= m_oor_q;
      x1_fy_q  <= m_fy_q;
      x1_fz_q  <= m_fz_q;
    end
  end

  logic signed [SAMPLE_W-1:0] x_m_q [4];
  logic                       x2_oor_q;
  logic [F-1:0]               x2_fy_q, x2_fz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) x_m_q[r] <= blend_add(x_a_q[r], x_prod_q[r]);
      x2_oor_q <= x1_oor_q;
      x2_fy_q  <= x1_fy_q;
      x2_fz_q  <= x1_fz_q;
    end
  end

  // Blend the y pairs within each z plane
  logic signed [PW-1:0]       y_prod_q [2];
  logic signed [SAMPLE_W-1:0] y_a_q [2];
  logic                       y1_oor_q;
  logic [F-1:0]               y1_fz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        y_prod_q[p] <= blend_mul(x_m_q[2*p], x_m_q[2*p+1], x2_fy_q);
        y_a_q[p]    <= x_m_q[2*p];
      end
      y1_oor_q <= x2_oor_q;
      y1_fz_q  <= x2_fz_q;
    end
  end

  logic signed [SAMPLE_W-1:0] y_p_q [2];
  logic                       y2_oor_q;
  logic [F-1:0]               y2_fz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 2; p++) y_p_q[p] <= blend_add(y_a_q[p], y_prod_q[p]);
      y2_oor_q <= y1_oor_q;
      y2_fz_q  <= y1_fz_q;
    end
  end

  // Blend the two planes along z
  logic signed [PW-1:0]       z_prod_q;
  logic signed [SAMPLE_W-1:0] z_a_q;
  logic                       z1_oor_q;
  res_t                       z_res_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_prod_q <= blend_mul(y_p_q[0], y_p_q[1], y2_fz_q);
      z_a_q    <= y_p_q[0];
      z1_oor_q <= y2_oor_q;
      z_res_q.oor    <= z1_oor_q;
      z_res_q.sample <= z1_oor_q ? '0 : blend_add(z_a_q, z_prod_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid entry
  // ---------------------------------------------------------------------------
  res_t head_q, skid_q;
  logic head_v_d, skid_v_d;
  logic head_ld, head_from_skid, skid_ld;
  logic push, pop;

  assign push = en & v_q[SZ2];
  assign pop  = head_v_q & out_ready_i;

  always_comb begin
    head_v_d       = head_v_q;
    skid_v_d       = skid_v_q;
    head_ld        = 1'b0;
    head_from_skid = 1'b0;
    skid_ld        = 1'b0;
    if (pop) begin
      if (skid_v_q) begin
        head_from_skid = 1'b1;
        skid_v_d       = 1'b0;
      end else begin
        head_v_d = push;
        head_ld  = push;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_ld  = 1'b1;
        skid_v_d = 1'b1;
      end else begin
        head_ld  = 1'b1;
        head_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_from_skid) begin
      head_q <= skid_q;
    end else if (head_ld) begin
      head_q <= z_res_q;
    end
    if (skid_ld) skid_q <= z_res_q;
  end

  assign out_valid_o    = head_v_q;
  assign sample_out_o   = head_q.sample;
  assign out_of_range_o = head_q.oor;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_implies_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q)
    else $error("skid entry held without a head entry");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_ready_i) |=> $stable(v_q))
    else $error("pipeline moved while output was full");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> head_v_q)
    else $error("pushed result not visible at output");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (sample_out_o == '0))
    else $error("out of range result with nonzero sample");

endmodule

[tb/tb.sv]
// Self-checking testbench for the trilinear grid upsampler.
module tb;
  import gtu_pkg::*;

  localparam int unsigned MAXS  = DEF_MAX_SIDE;
  localparam int unsigned FRACB = DEF_FRAC_BITS;
  localparam int unsigned DRAIN = 40;
  localparam int unsigned WD_LIMIT = 20000;

  // Predicted interpolation results, checked in order
  class interp_scoreboard;
    logic signed [SAMPLE_W-1:0] grid [MAXS*MAXS*MAXS];
    int unsigned scale;
    int unsigned side;
    logic signed [SAMPLE_W-1:0] want_sample [$];
    logic want_oor [$];
    int errors;
    int queries;
    int oor_seen;

    function new();
      scale = SCALE_RST;
      side = SIDE_RST;
      errors = 0;
      queries = 0;
      oor_seen = 0;
    endfunction

    function int blend(int a, int b, int unsigned f);
      longint p;
      p = longint'(b - a) * longint'(f);
      return a + int'(p / (longint'(1) << FRACB));
    endfunction

    function int corner(int unsigned cx, int unsigned cy, int unsigned cz, int unsigned sd);
      int unsigned idx;
      idx = (cz * sd + cy) * sd + cx;
      if (idx >= MAXS*MAXS*MAXS) return 0;
      return int'(grid[idx]);
    endfunction

    // Note an accepted item and queue its expected result
    function void note_item(logic act, int unsigned li, logic signed [SAMPLE_W-1:0] lv,
                            int unsigned cx, int unsigned cy, int unsigned cz);
      int unsigned sc, sd, crd[3], cell_idx[3], frac[3];
      int m00, m01, m10, m11, p0, p1, r;
      bit oor;
      if (act == ACT_LOAD) begin
        if (li < MAXS*MAXS*MAXS) grid[li] = lv;
        return;
      end
      queries++;
      sc = (scale == 0) ? 1 : scale;
      sd = (side > MAXS) ? MAXS : side;
      crd[0] = cx; crd[1] = cy; crd[2] = cz;
      oor = 0;
      for (int i = 0; i < 3; i++) begin
        cell_idx[i] = crd[i] / sc;
        frac[i] = ((crd[i] % sc) << FRACB) / sc;
        if (cell_idx[i] + 1 >= sd) oor = 1;
      end
      if (oor) begin
        oor_seen++;
        want_sample.push_back('0);
        want_oor.push_back(1'b1);
        return;
      end
      m00 = blend(corner(cell_idx[0], cell_idx[1], cell_idx[2], sd),
                  corner(cell_idx[0]+1, cell_idx[1], cell_idx[2], sd), frac[0]);
      m01 = blend(corner(cell_idx[0], cell_idx[1]+1, cell_idx[2], sd),
                  corner(cell_idx[0]+1, cell_idx[1]+1, cell_idx[2], sd), frac[0]);
      m10 = blend(corner(cell_idx[0], cell_idx[1], cell_idx[2]+1, sd),
                  corner(cell_idx[0]+1, cell_idx[1], cell_idx[2]+1, sd), frac[0]);
      m11 = blend(corner(cell_idx[0], cell_idx[1]+1, cell_idx[2]+1, sd),
                  corner(cell_idx[0]+1, cell_idx[1]+1, cell_idx[2]+1, sd), frac[0]);
      p0 = blend(m00, m01, frac[1]);
      p1 = blend(m10, m11, frac[1]);
      r = blend(p0, p1, frac[2]);
      want_sample.push_back(r[SAMPLE_W-1:0]);
      want_oor.push_back(1'b0);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(logic signed [SAMPLE_W-1:0] s, logic o);
      logic signed [SAMPLE_W-1:0] es;
      logic eo;
      if (want_sample.size() == 0) begin
        $error("unexpected result sample_out=%0d out_of_range=%0b", s, o);
        errors++;
        return;
      end
      es = want_sample.pop_front();
      eo = want_oor.pop_front();
      if (s !== es) begin
        $error("sample_out expected %0d actual %0d", es, s);
        errors++;
      end
      if (o !== eo) begin
        $error("out_of_range expected %0b actual %0b", eo, o);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, action_i;
  logic [LOAD_IDX_W-1:0] load_index_i;
  logic signed [SAMPLE_W-1:0] load_value_i;
  logic [COORD_W-1:0] coord_x_i, coord_y_i, coord_z_i;
  logic out_valid_o, out_ready_i, out_of_range_o;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  interp_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int unsigned quiet_cycles;
  bit written [MAXS*MAXS*MAXS];

  grid_trilinear_upsample u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Accept results, stall the receiver at random, run the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(sample_out_o, out_of_range_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog: no item moved in %0d cycles", WD_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Write one register through the configuration port
  task automatic reg_write(logic idx, int unsigned val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << REG_IDX_BIT; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_SCALE) sb.scale = val & 32'h1FF;
    else sb.side = val & 32'h3F;
  endtask

  // Present one item, hold it until accepted
  task automatic send_item(logic act, int unsigned li, int lv,
                           int unsigned cx, int unsigned cy, int unsigned cz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; action_i <= act;
    load_index_i <= LOAD_IDX_W'(li); load_value_i <= SAMPLE_W'(lv);
    coord_x_i <= COORD_W'(cx); coord_y_i <= COORD_W'(cy); coord_z_i <= COORD_W'(cz);
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, li, SAMPLE_W'(lv), cx, cy, cz);
    if (act == ACT_LOAD && li < MAXS*MAXS*MAXS) written[li] = 1'b1;
  endtask

  // Lower valid and wait for every expected result plus pipeline drain
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.want_sample.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic load(int unsigned li, int lv);
    send_item(ACT_LOAD, li, lv, 0, 0, 0);
  endtask

  // Random sample, the extremes sprinkled in
  function automatic int rand_sample();
    int v;
    case ($urandom_range(7))
      0: v = -32768;
      1: v = 32767;
      default: v = $urandom_range(65535) - 32768;
    endcase
    return v;
  endfunction

  // For an in-range query, load any unwritten corner of its cell, then send the query
  task automatic query(int unsigned cx, int unsigned cy, int unsigned cz);
    int unsigned sc, sd, cl[3], idx;
    bit oor;
    sc = (sb.scale == 0) ? 1 : sb.scale;
    sd = (sb.side > MAXS) ? MAXS : sb.side;
    cl[0] = cx / sc; cl[1] = cy / sc; cl[2] = cz / sc;
    oor = 0;
    for (int i = 0; i < 3; i++) if (cl[i] + 1 >= sd) oor = 1;
    if (!oor) begin
      for (int k = 0; k < 8; k++) begin
        idx = ((cl[2] + k[2]) * sd + cl[1] + k[1]) * sd + cl[0] + k[0];
        if (!written[idx]) load(idx, rand_sample());
      end
    end
    send_item(ACT_QUERY, 0, 0, cx, cy, cz);
  endtask

  // Random query for the given scale and side, mostly in the first cells
  task automatic rand_query(int unsigned sc, int unsigned sd);
    int unsigned c[3], lim;
    for (int i = 0; i < 3; i++) begin
      lim = ((sd - 1 > 2) ? 2 : sd - 1) * sc;
      if (lim > 8192) lim = 8192;
      if ($urandom_range(9) == 0) c[i] = $urandom_range(8191);
      else c[i] = $urandom_range(lim - 1);
    end
    query(c[0], c[1], c[2]);
  endtask

  initial begin
    int unsigned scales[6] = '{1, 256, 3, 100, 17, 0};
    int unsigned sides[6]  = '{32, 2, 7, 32, 63, 16};
    sb = new();
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b1;
    action_i = ACT_LOAD; load_index_i = '0; load_value_i = '0;
    coord_x_i = '0; coord_y_i = '0; coord_z_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load the last entry of the store
    load(32767, 16'sh1234);
    drain();

    // Directed: corners and the edge of the grid at reset settings
    query(0, 0, 0);
    query(30, 30, 30);
    query(31, 0, 0);
    query(8191, 8191, 8191);
    load(0, -32768); load(1, 32767);
    query(0, 0, 0);
    drain();
    reg_write(REG_SCALE, 256);
    reg_write(REG_SIDE, 32);
    query(255, 255, 255);
    query(128, 7935, 1);
    query(7936, 0, 0);
    query(8191, 0, 0);
    drain();
    // Side of one and zero: everything is outside
    reg_write(REG_SIDE, 1);
    query(0, 0, 0);
    drain();
    reg_write(REG_SIDE, 0);
    reg_write(REG_SCALE, 0);
    query(0, 0, 0);
    drain();
    reg_write(REG_SIDE, 63);
    query(30, 29, 0);
    query(31, 29, 0);
    drain();
    reg_write(REG_SCALE, 511);
    query(8191, 510, 4000);
    drain();

    // Random phases across settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      reg_write(REG_SCALE, scales[ph % 6]);
      reg_write(REG_SIDE, sides[ph % 6]);
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(4) == 0)
          load($urandom_range(MAXS*MAXS*MAXS - 1), $urandom_range(65535) - 32768);
        else
          rand_query((scales[ph % 6] == 0) ? 1 : scales[ph % 6],
                     (sides[ph % 6] > MAXS) ? MAXS : sides[ph % 6]);
        if (n == 26) drain();
      end
      drain();
    end

    $display("covered %0d queries (%0d outside the grid) over 8 settings and 4 idling mixes",
             sb.queries, sb.oor_seen);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
